### src/dihed_pkg.sv
package dihed_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int ANGLE_FRAC_DEF = 16;

	// Multiplier operand slice width and the fixed latency of dihed_mul.
	localparam int MUL_CHUNK = 32;
	localparam int MUL_LAT = 4;

	// Angle constants carry 60 fraction bits.
	localparam int CORDIC_ITERS = 60;
	localparam int CORDIC_FRAC = 60;
	localparam logic [63:0] PI60 = 64'h3243F6A8885A308D;
	localparam logic [63:0] HALFPI60 = 64'h1921FB54442D1846;
	localparam logic [63:0] QUARTERPI60 = 64'h0C90FDAA22168C23;

	typedef struct packed {
		logic xneg;
		logic yneg;
		logic zero;
	} flags_t;

	// Arctangent of 2^-i at 60 fraction bits, from the alternating series.
	// Evaluated at elaboration only; the quotient is formed by shift and subtract.
	function automatic logic [63:0] atan_entry(input int i);
		logic [63:0] s;
		logic [63:0] num;
		logic [63:0] term;
		logic [63:0] rem;
		int k;
		int e;
		int d;
		int idx;
		if (i == 0) begin
			return QUARTERPI60;
		end
		s = '0;
		k = 0;
		e = 63 - i;
		while (e >= 0) begin
			num = 64'd1 << e;
			d = 2 * k + 1;
			term = '0;
			rem = '0;
			for (idx = 63; idx >= 0; idx--) begin
				rem = {rem[62:0], num[idx]};
				if (rem >= 64'(d)) begin
					rem = rem - 64'(d);
					term[idx] = 1'b1;
				end
			end
			if (k % 2 == 1) begin
				s = s - term;
			end else begin
				s = s + term;
			end
			k = k + 1;
			e = 63 - i * (2 * k + 1);
		end
		return (s + 64'd4) >> 3;
	endfunction

endpackage

### src/dihed_dly.sv
module dihed_dly #(
	parameter int W = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DEPTH; j++) begin
				line_q[j] <= '0;
			end
		end else begin
			line_q[0] <= d;
			for (int j = 1; j < DEPTH; j++) begin
				line_q[j] <= line_q[j-1];
			end
		end
	end

	assign q = line_q[DEPTH-1];

endmodule

### src/dihed_mul.sv
module dihed_mul import dihed_pkg::*; #(
	parameter int WA = 33,
	parameter int WB = 33
) (
	input  logic                    clk,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic signed [WA+WB-1:0] p
);

	localparam int NA = (WA + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int NB = (WB + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int AUW = NA * MUL_CHUNK;
	localparam int BUW = NB * MUL_CHUNK;
	localparam int PW = WA + WB;
	localparam int SW = AUW + BUW;

	logic [AUW-1:0]         ua_s1;
	logic [BUW-1:0]         ub_s1;
	logic                   neg_s1, neg_s2, neg_s3;
	logic [2*MUL_CHUNK-1:0] pp_s2 [NA][NB];
	logic [PW-1:0]          sum_s3;
	logic [SW-1:0]          acc;

	// Magnitudes are multiplied slice by slice; the sign is restored at the end.
	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (SW'(pp_s2[i][j]) << (MUL_CHUNK * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		ua_s1 <= AUW'($unsigned(a[WA-1] ? -a : a));
		ub_s1 <= BUW'($unsigned(b[WB-1] ? -b : b));
		neg_s1 <= a[WA-1] ^ b[WB-1];
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				pp_s2[i][j] <= ua_s1[i*MUL_CHUNK +: MUL_CHUNK] * ub_s1[j*MUL_CHUNK +: MUL_CHUNK];
			end
		end
		neg_s2 <= neg_s1;
		sum_s3 <= acc[PW-1:0];
		neg_s3 <= neg_s2;
		p <= neg_s3 ? -$signed(sum_s3) : $signed(sum_s3);
	end

endmodule

### src/dihed_isqrt.sv
module dihed_isqrt #(
	parameter int NW = 66
) (
	input  logic                  clk,
	input  logic [NW-1:0]         n,
	output logic [(NW+1)/2-1:0]   r
);

	localparam int RW = (NW + 1) / 2;

	logic [NW-1:0] rem_s  [RW+1];
	logic [RW-1:0] root_s [RW+1];

	assign rem_s[0] = n;
	assign root_s[0] = '0;

	// One result bit per stage, most significant first; the remainder
	// keeps n minus the square of the partial root.
	for (genvar k = 0; k < RW; k++) begin : g_bit
		localparam int B = RW - 1 - k;
		logic [NW+1:0] trial;
		assign trial = ((NW+2)'(root_s[k]) << (B + 1)) | ((NW+2)'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if ((NW+2)'(rem_s[k]) >= trial) begin
				rem_s[k+1] <= rem_s[k] - trial[NW-1:0];
				root_s[k+1] <= root_s[k] | (RW'(1) << B);
			end else begin
				rem_s[k+1] <= rem_s[k];
				root_s[k+1] <= root_s[k];
			end
		end
	end

	assign r = root_s[RW];

endmodule

### src/dihed_atan.sv
module dihed_atan import dihed_pkg::*; #(
	parameter int AW = 137,
	parameter int FRAC = ANGLE_FRAC_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld_in,
	input  logic signed [AW-1:0]  x,
	input  logic signed [AW-1:0]  y,
	output logic                  done,
	output logic signed [FRAC+2:0] torsion,
	output logic                  degenerate
);

	localparam int TW = FRAC + 3;
	localparam int SH = CORDIC_FRAC - FRAC;
	localparam int NW = (AW > 60) ? AW : 60;
	localparam int NS = $clog2(NW);
	localparam int SC = 1 + NS + CORDIC_ITERS;
	localparam int L = SC + 2;

	logic [AW-1:0]      ax_s1, ay_s1;
	logic [NW-1:0]      nx_s [NS+1];
	logic [NW-1:0]      ny_s [NS+1];
	logic signed [63:0] cx_s [CORDIC_ITERS+1];
	logic signed [63:0] cy_s [CORDIC_ITERS+1];
	logic signed [63:0] cz_s [CORDIC_ITERS+1];
	logic [63:0]        a_s;
	flags_t             fl_s [1:SC+1];
	logic               vld_s [1:L-1];
	logic signed [63:0] zc;
	logic [63:0]        q;
	logic [63:0]        res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j < L; j++) begin
				vld_s[j] <= 1'b0;
			end
			done <= 1'b0;
		end else begin
			vld_s[1] <= vld_in;
			for (int j = 2; j < L; j++) begin
				vld_s[j] <= vld_s[j-1];
			end
			done <= vld_s[L-1];
		end
	end

	always_ff @(posedge clk) begin
		ax_s1 <= $unsigned(x[AW-1] ? -x : x);
		ay_s1 <= $unsigned(y[AW-1] ? -y : y);
		fl_s[1] <= '{xneg: x[AW-1], yneg: y[AW-1], zero: (x == '0) && (y == '0)};
		for (int j = 2; j <= SC + 1; j++) begin
			fl_s[j] <= fl_s[j-1];
		end
	end

	assign nx_s[0] = NW'(ax_s1);
	assign ny_s[0] = NW'(ay_s1);

	// Left shift both magnitudes together until the larger one reaches the top bit.
	for (genvar k = 0; k < NS; k++) begin : g_norm
		localparam int STEP = 1 << (NS - 1 - k);
		always_ff @(posedge clk) begin
			if ((nx_s[k][NW-1 -: STEP] | ny_s[k][NW-1 -: STEP]) == '0) begin
				nx_s[k+1] <= nx_s[k] << STEP;
				ny_s[k+1] <= ny_s[k] << STEP;
			end else begin
				nx_s[k+1] <= nx_s[k];
				ny_s[k+1] <= ny_s[k];
			end
		end
	end

	assign cx_s[0] = $signed({4'b0, nx_s[NS][NW-1 -: 60]});
	assign cy_s[0] = $signed({4'b0, ny_s[NS][NW-1 -: 60]});
	assign cz_s[0] = '0;

	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
		localparam logic [63:0] ANG = atan_entry(i);
		logic signed [63:0] ys, xs;
		assign ys = (cy_s[i] >= 0) ? (cy_s[i] >>> i) : -((-cy_s[i]) >>> i);
		assign xs = $signed($unsigned(cx_s[i]) >> i);
		always_ff @(posedge clk) begin
			if (cy_s[i] >= 0) begin
				cx_s[i+1] <= cx_s[i] + ys;
				cy_s[i+1] <= cy_s[i] - xs;
				cz_s[i+1] <= cz_s[i] + $signed(ANG);
			end else begin
				cx_s[i+1] <= cx_s[i] - ys;
				cy_s[i+1] <= cy_s[i] + xs;
				cz_s[i+1] <= cz_s[i] - $signed(ANG);
			end
		end
	end

	always_comb begin
		zc = cz_s[CORDIC_ITERS];
		if (zc < 0) begin
			zc = '0;
		end
		if (zc > $signed(HALFPI60)) begin
			zc = $signed(HALFPI60);
		end
		q = (a_s + (64'd1 << (SH - 1))) >> SH;
		res = fl_s[SC+1].yneg ? -q : q;
	end

	always_ff @(posedge clk) begin
		a_s <= fl_s[SC].xneg ? (PI60 - $unsigned(zc)) : $unsigned(zc);
		torsion <= fl_s[SC+1].zero ? '0 : $signed(res[TW-1:0]);
		degenerate <= fl_s[SC+1].zero;
	end

endmodule

### src/dihedral_angle_four_points_top.sv
// Dihedral angle of four 3-D points, one transfer per clock cycle. Assert start
// with the twelve coordinates; busy is always low, so every start cycle is a
// transfer. The angle comes out a fixed number of cycles later, marked by done
// for exactly one cycle, and the receiver cannot stall it: it must take torsion
// and degenerate in that cycle. The atan2 arguments are 136 bits wide at the
// default 32-bit coordinates. The delay is set by the 60-step CORDIC pipeline,
// the bit-per-stage square root and the chained multipliers of four sliced
// stages each. torsion is in radians with ANGLE_FRAC_BITS fraction bits;
// when both atan2 arguments are exactly zero it reads 0 and degenerate is 1.
module dihedral_angle_four_points_top import dihed_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [COORD_WIDTH-1:0]   first_x,
	input  logic signed [COORD_WIDTH-1:0]   first_y,
	input  logic signed [COORD_WIDTH-1:0]   first_z,
	input  logic signed [COORD_WIDTH-1:0]   second_x,
	input  logic signed [COORD_WIDTH-1:0]   second_y,
	input  logic signed [COORD_WIDTH-1:0]   second_z,
	input  logic signed [COORD_WIDTH-1:0]   third_x,
	input  logic signed [COORD_WIDTH-1:0]   third_y,
	input  logic signed [COORD_WIDTH-1:0]   third_z,
	input  logic signed [COORD_WIDTH-1:0]   fourth_x,
	input  logic signed [COORD_WIDTH-1:0]   fourth_y,
	input  logic signed [COORD_WIDTH-1:0]   fourth_z,
	output logic                            done,
	output logic signed [ANGLE_FRAC_BITS+2:0] torsion,
	output logic                            degenerate
);

	// Widths of every intermediate, chosen so that nothing ever overflows.
	localparam int BW = COORD_WIDTH + 1;        // bond vector component
	localparam int CW = 2 * BW + 1;             // cross product component
	localparam int MWD = BW + CW + 2;           // triple product b1.(b2 x b3)
	localparam int SQW = 2 * BW;                // |b2|^2, unsigned
	localparam int RW = (SQW + 1) / 2;          // |b2|
	localparam int XW = 2 * CW + 2;             // X argument
	localparam int YW = RW + 1 + MWD;           // Y argument
	localparam int AW = (XW > YW) ? XW : YW;
	localparam int VLD_DEPTH = 3 * MUL_LAT + 2 + RW;

	logic signed [COORD_WIDTH-1:0] pt1 [3], pt2 [3], pt3 [3], pt4 [3];
	logic signed [BW-1:0] b1_s1 [3], b2_s1 [3], b3_s1 [3];
	logic signed [BW-1:0] b1_d [3], b2_d [3];
	logic [3*BW-1:0] b1_pack, b2_pack, b1_pack_d, b2_pack_d;
	logic vld_s1, vld_a;

	logic signed [2*BW-1:0] x23a [3], x23b [3], x12a [3], x12b [3];
	logic signed [CW-1:0] c23_s2 [3], c12_s2 [3];
	logic signed [BW+CW-1:0] dm [3];
	logic signed [2*BW-1:0] ds [3];
	logic signed [2*CW-1:0] dx [3];
	logic signed [MWD-1:0] m_s3;
	logic [SQW-1:0] sq_s3;
	logic signed [XW-1:0] x_s3;
	logic [RW-1:0] len;
	logic [MWD-1:0] m_d;
	logic [XW-1:0] x_d;
	logic signed [YW-1:0] y_p;

	// The block never refuses a start: an item may enter in every cycle.
	assign busy = 1'b0;

	assign pt1 = '{first_x, first_y, first_z};
	assign pt2 = '{second_x, second_y, second_z};
	assign pt3 = '{third_x, third_y, third_z};
	assign pt4 = '{fourth_x, fourth_y, fourth_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	// Stage one: the three bond vectors.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			b1_s1[k] <= BW'(pt2[k]) - BW'(pt1[k]);
			b2_s1[k] <= BW'(pt3[k]) - BW'(pt2[k]);
			b3_s1[k] <= BW'(pt4[k]) - BW'(pt3[k]);
		end
	end

	// Cross products b2 x b3 and b1 x b2, each component two products apart.
	for (genvar k = 0; k < 3; k++) begin : g_cross
		localparam int P = (k + 1) % 3;
		localparam int Q = (k + 2) % 3;
		dihed_mul #(.WA(BW), .WB(BW)) u_m23a (.clk, .a(b2_s1[P]), .b(b3_s1[Q]), .p(x23a[k]));
		dihed_mul #(.WA(BW), .WB(BW)) u_m23b (.clk, .a(b2_s1[Q]), .b(b3_s1[P]), .p(x23b[k]));
		dihed_mul #(.WA(BW), .WB(BW)) u_m12a (.clk, .a(b1_s1[P]), .b(b2_s1[Q]), .p(x12a[k]));
		dihed_mul #(.WA(BW), .WB(BW)) u_m12b (.clk, .a(b1_s1[Q]), .b(b2_s1[P]), .p(x12b[k]));
		always_ff @(posedge clk) begin
			c23_s2[k] <= CW'(x23a[k]) - CW'(x23b[k]);
			c12_s2[k] <= CW'(x12a[k]) - CW'(x12b[k]);
		end
	end

	// b1 and b2 wait alongside the cross products.
	assign b1_pack = {b1_s1[2], b1_s1[1], b1_s1[0]};
	assign b2_pack = {b2_s1[2], b2_s1[1], b2_s1[0]};

	dihed_dly #(.W(3*BW), .DEPTH(MUL_LAT+1)) u_dly_b1 (
		.clk, .arst_n, .d(b1_pack), .q(b1_pack_d)
	);
	dihed_dly #(.W(3*BW), .DEPTH(MUL_LAT+1)) u_dly_b2 (
		.clk, .arst_n, .d(b2_pack), .q(b2_pack_d)
	);

	for (genvar k = 0; k < 3; k++) begin : g_dot
		assign b1_d[k] = $signed(b1_pack_d[k*BW +: BW]);
		assign b2_d[k] = $signed(b2_pack_d[k*BW +: BW]);
		dihed_mul #(.WA(BW), .WB(CW)) u_mm (.clk, .a(b1_d[k]), .b(c23_s2[k]), .p(dm[k]));
		dihed_mul #(.WA(BW), .WB(BW)) u_ms (.clk, .a(b2_d[k]), .b(b2_d[k]), .p(ds[k]));
		dihed_mul #(.WA(CW), .WB(CW)) u_mx (.clk, .a(c12_s2[k]), .b(c23_s2[k]), .p(dx[k]));
	end

	// Dot product sums: triple product, squared length of b2 and X.
	always_ff @(posedge clk) begin
		m_s3 <= MWD'(dm[0]) + MWD'(dm[1]) + MWD'(dm[2]);
		sq_s3 <= $unsigned(ds[0]) + $unsigned(ds[1]) + $unsigned(ds[2]);
		x_s3 <= XW'(dx[0]) + XW'(dx[1]) + XW'(dx[2]);
	end

	dihed_isqrt #(.NW(SQW)) u_isqrt (.clk, .n(sq_s3), .r(len));

	dihed_dly #(.W(MWD), .DEPTH(RW)) u_dly_m (
		.clk, .arst_n, .d(m_s3), .q(m_d)
	);
	dihed_dly #(.W(XW), .DEPTH(RW+MUL_LAT)) u_dly_x (
		.clk, .arst_n, .d(x_s3), .q(x_d)
	);

	// Y = |b2| * b1.(b2 x b3); the root is non-negative, so it gets a zero sign bit.
	dihed_mul #(.WA(RW+1), .WB(MWD)) u_my (
		.clk, .a($signed({1'b0, len})), .b($signed(m_d)), .p(y_p)
	);

	dihed_dly #(.W(1), .DEPTH(VLD_DEPTH)) u_dly_vld (
		.clk, .arst_n, .d(vld_s1), .q(vld_a)
	);

	// Sign handling, normalization, CORDIC vectoring and rounding.
	dihed_atan #(.AW(AW), .FRAC(ANGLE_FRAC_BITS)) u_atan (
		.clk,
		.arst_n,
		.vld_in(vld_a),
		.x(AW'($signed(x_d))),
		.y(AW'(y_p)),
		.done,
		.torsion,
		.degenerate
	);

endmodule

### sim/dihedral_angle_four_points_checker.sv
module dihedral_angle_four_points_checker import dihed_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic signed [11:0][31:0] points,
	input  logic                     done,
	input  logic signed [18:0]       torsion,
	input  logic                     degenerate,
	output int                       pending,
	output int                       fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [191:0] wide_t;
	typedef struct packed {
		logic signed [18:0] torsion;
		logic               degenerate;
	} angle_t;

	angle_t angle_q[$];
	longint unsigned arctan_steps[60];

	initial begin
		longint unsigned s;
		longint unsigned term;
		int k;
		int e;
		arctan_steps[0] = QUARTERPI60;
		for (int i = 1; i < 60; i++) begin
			s = 0;
			k = 0;
			e = 63 - i;
			while (e >= 0) begin
				term = (64'd1 << e) / longint'(2 * k + 1);
				if (k % 2 == 1) begin
					s = s - term;
				end else begin
					s = s + term;
				end
				k++;
				e = 63 - i * (2 * k + 1);
			end
			arctan_steps[i] = (s + 4) >> 3;
		end
	end

	function automatic wide_t cross_term(input wide_t a, input wide_t b, input wide_t c,
		input wide_t d);
		return a * b - c * d;
	endfunction

	// Exact dihedral angle: wide integer geometry followed by the fixed CORDIC.
	function automatic angle_t dihedral_of(input logic signed [11:0][31:0] pt);
		wide_t b1[3], b2[3], b3[3], n12[3], n23[3];
		wide_t triple, sumsq, cosv, sinv, root, ax, ay;
		logic xneg, yneg;
		int h;
		longint x, y, z, ys, xs;
		longint unsigned mag, q;
		angle_t r;
		// A select of the packed array is unsigned, so each coordinate is
		// made signed before it is widened.
		for (int k = 0; k < 3; k++) begin
			b1[k] = wide_t'($signed(pt[3 + k])) - wide_t'($signed(pt[k]));
			b2[k] = wide_t'($signed(pt[6 + k])) - wide_t'($signed(pt[3 + k]));
			b3[k] = wide_t'($signed(pt[9 + k])) - wide_t'($signed(pt[6 + k]));
		end
		for (int k = 0; k < 3; k++) begin
			n23[k] = cross_term(b2[(k + 1) % 3], b3[(k + 2) % 3], b2[(k + 2) % 3],
				b3[(k + 1) % 3]);
			n12[k] = cross_term(b1[(k + 1) % 3], b2[(k + 2) % 3], b1[(k + 2) % 3],
				b2[(k + 1) % 3]);
		end
		triple = 0;
		sumsq = 0;
		cosv = 0;
		for (int k = 0; k < 3; k++) begin
			triple += b1[k] * n23[k];
			sumsq += b2[k] * b2[k];
			cosv += n12[k] * n23[k];
		end
		root = 0;
		for (int b = 62; b >= 0; b--) begin
			wide_t t;
			t = root | (wide_t'(1) << b);
			if (t * t <= sumsq) root = t;
		end
		sinv = root * triple;
		r = '0;
		if (cosv == 0 && sinv == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		xneg = cosv < 0;
		yneg = sinv < 0;
		ax = xneg ? -cosv : cosv;
		ay = yneg ? -sinv : sinv;
		h = 0;
		for (int b = 191; b >= 0; b--) begin
			if (ax[b] || ay[b]) begin
				h = b;
				break;
			end
		end
		if (h > 59) begin
			x = longint'(ax >> (h - 59));
			y = longint'(ay >> (h - 59));
		end else begin
			x = longint'(ax) << (59 - h);
			y = longint'(ay) << (59 - h);
		end
		z = 0;
		for (int i = 0; i < 60; i++) begin
			ys = (y >= 0) ? (y >>> i) : -((-y) >>> i);
			xs = longint'($unsigned(x) >> i);
			if (y >= 0) begin
				x += ys;
				y -= xs;
				z += longint'(arctan_steps[i]);
			end else begin
				x -= ys;
				y += xs;
				z -= longint'(arctan_steps[i]);
			end
		end
		if (z < 0) z = 0;
		if (z > longint'(HALFPI60)) z = longint'(HALFPI60);
		mag = xneg ? (PI60 - z) : z;
		q = (mag + (64'd1 << 43)) >> 44;
		r.torsion = yneg ? -(19'(q)) : 19'(q);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		angle_t want;
		if (!arst_n) begin
			angle_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (angle_q.size() == 0) begin
					$display("%0t: result with no transfer waiting: torsion %0d degenerate %0b",
						$time, torsion, degenerate);
					fail_count <= fail_count + 1;
				end else begin
					want = angle_q.pop_front();
					if (want.torsion !== torsion || want.degenerate !== degenerate) begin
						$display("%0t: torsion expected %0d got %0d, degenerate expected %0b got %0b",
							$time, want.torsion, torsion, want.degenerate, degenerate);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) angle_q.insert(angle_q.size(), dihedral_of(points));
			pending <= angle_q.size();
		end
	end
endmodule

### sim/dihedral_angle_four_points_top_test.sv
// Drives quadruples of points into the dihedral angle block and leaves all
// prediction and comparison to the checker that sits beside it.
module dihedral_angle_four_points_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int UNIT = 1 << 16;
	localparam int RANDOM_ITEMS = 400;
	localparam int IDLE_LIMIT = 3000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [11:0][31:0] points;
	logic done;
	logic signed [18:0] torsion;
	logic degenerate;
	int pending;
	int fail_count;
	int idle_cycles;

	dihedral_angle_four_points_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_x(points[0]), .first_y(points[1]), .first_z(points[2]),
		.second_x(points[3]), .second_y(points[4]), .second_z(points[5]),
		.third_x(points[6]), .third_y(points[7]), .third_z(points[8]),
		.fourth_x(points[9]), .fourth_y(points[10]), .fourth_z(points[11]),
		.done(done), .torsion(torsion), .degenerate(degenerate)
	);

	dihedral_angle_four_points_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .points(points),
		.done(done), .torsion(torsion), .degenerate(degenerate),
		.pending(pending), .fail_count(fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The watchdog counts cycles in which neither side makes a transfer.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// One transfer. start stays high across the edge; busy is sampled at the
	// falling edge so that the acceptance decision never races the block.
	task automatic send_points(input logic signed [11:0][31:0] p);
		logic busy_seen;
		start <= 1'b1;
		points <= p;
		forever begin
			@(negedge clk);
			busy_seen = busy;
			@(posedge clk);
			if (!busy_seen) break;
		end
	endtask

	// Idle gaps: mostly none, sometimes short, rarely long. A gap lowers start
	// only when there is one, so a back-to-back stream keeps start high.
	task automatic maybe_idle();
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		len = 0;
		if (pick >= 97) len = $urandom_range(40, 200);
		else if (pick >= 70) len = $urandom_range(1, 5);
		if (len > 0) begin
			start <= 1'b0;
			repeat (len) @(posedge clk);
		end
	endtask

	function automatic logic signed [11:0][31:0] quad(input int c[12]);
		logic signed [11:0][31:0] p;
		for (int k = 0; k < 12; k++) p[k] = c[k];
		return p;
	endfunction

	// Four points with coordinates in a moderate box or across the full range,
	// optionally forced into a plane (angle zero or pi) or onto a line (degenerate).
	function automatic logic signed [11:0][31:0] random_quad();
		logic signed [11:0][31:0] p;
		int span;
		int shape;
		shape = $urandom_range(0, 9);
		span = (shape == 0) ? 0 : $urandom_range(1, 1 << 24);
		for (int k = 0; k < 12; k++) begin
			if (shape == 0) p[k] = $urandom();
			else p[k] = $signed($urandom_range(0, 2 * span)) - span;
		end
		if (shape == 1) begin
			// The fourth point is the first moved along the middle bond, so the
			// points lie in one plane.
			for (int k = 0; k < 3; k++) p[9 + k] = p[6 + k] + p[k] - p[3 + k];
		end else if (shape == 2) begin
			for (int k = 0; k < 3; k++) p[9 + k] = p[6 + k] - p[k] + p[3 + k];
		end else if (shape == 3) begin
			// First three points on one line.
			for (int k = 0; k < 3; k++) p[6 + k] = 2 * p[3 + k] - p[k];
		end
		return p;
	endfunction

	initial begin
		start = 1'b0;
		points = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All points equal: both atan2 arguments are zero.
		send_points('0);
		// First three points collinear.
		send_points(quad('{0, 0, 0, UNIT, 0, 0, 2 * UNIT, 0, 0, 3 * UNIT, UNIT, 0}));
		// Planar, cis: the angle is zero.
		send_points(quad('{0, UNIT, 0, 0, 0, 0, UNIT, 0, 0, UNIT, UNIT, 0}));
		// Planar, trans: Y is zero and X negative, so the angle is +pi.
		send_points(quad('{0, UNIT, 0, 0, 0, 0, UNIT, 0, 0, UNIT, -UNIT, 0}));
		// Perpendicular planes: X is zero, both signs of the angle.
		send_points(quad('{0, UNIT, 0, 0, 0, 0, UNIT, 0, 0, UNIT, 0, UNIT}));
		send_points(quad('{0, UNIT, 0, 0, 0, 0, UNIT, 0, 0, UNIT, 0, -UNIT}));
		// Obtuse angles of both signs.
		send_points(quad('{0, UNIT, 0, 0, 0, 0, UNIT, 0, 0, UNIT, -UNIT, UNIT}));
		send_points(quad('{0, UNIT, 0, 0, 0, 0, UNIT, 0, 0, UNIT, -UNIT, -UNIT}));
		// Tiny offsets: the smallest nonzero geometry.
		send_points(quad('{0, 1, 0, 0, 0, 0, 1, 0, 0, 1, 1, 1}));
		// Extreme coordinates, which give the widest bond vectors, and all points at -1.
		send_points(quad('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh7fffffff}));
		send_points(quad('{32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}));
		send_points(quad('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1}));
		send_points(quad('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000}));

		// Hold off until every angle in flight has come back.
		start <= 1'b0;
		wait (pending == 0);
		@(posedge clk);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			send_points(random_quad());
			maybe_idle();
		end
		start <= 1'b0;

		wait (pending == 0);
		repeat (150) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
